/* rtl/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types, constants and helpers for the line pixel rasterizer.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // Limits of a line command
  localparam int MAX_EXTENT = 63;
  localparam int COORD_BITS = 16;

  // Port field widths
  localparam int POS_W   = 16;
  localparam int EXT_W   = 7;
  localparam int COLOR_W = 32;

  // Pixel counts run 1 .. MAX_EXTENT+1
  localparam int CNT_W = $clog2(MAX_EXTENT + 2);

  // Command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_W-1:0]      count_t;

  // Classified line command
  typedef struct packed {
    coord_t               x;
    coord_t               y;
    logic [COLOR_W-1:0]   color;
    count_t               major;
    count_t               minor;
    logic                 x_major;
    logic                 neg_x;
    logic                 neg_y;
  } line_cmd_t;

  // Pixel count of one axis: saturated magnitude plus one
  function automatic count_t extent_count(logic [EXT_W-1:0] ext);
    logic [EXT_W-1:0] mag;
    mag = ext[EXT_W-1] ? (~ext + EXT_W'(1)) : ext;
    if (mag > EXT_W'(MAX_EXTENT)) begin
      mag = EXT_W'(MAX_EXTENT);
    end
    return count_t'(mag) + count_t'(1);
  endfunction

  // Port coordinate to internal wrapped coordinate
  function automatic coord_t pos_to_coord(logic [POS_W-1:0] pos);
    return coord_t'(signed'(pos));
  endfunction

  // Internal coordinate to port value (sign extend or keep low bits)
  function automatic logic [POS_W-1:0] coord_to_pos(coord_t c);
    return POS_W'(signed'(c));
  endfunction

endpackage

/* rtl/lpr_front.sv */
// ----------------------------------------------------------------------------
// lpr_front
// Accepts line commands and classifies them: pixel counts, major axis and
// step directions, ready for the stepping back end.
// ----------------------------------------------------------------------------
module lpr_front import lpr_pkg::*; (
  input  logic               push,
  input  logic [POS_W-1:0]   start_x_i,
  input  logic [POS_W-1:0]   start_y_i,
  input  logic [EXT_W-1:0]   extent_x_i,
  input  logic [EXT_W-1:0]   extent_y_i,
  input  logic [COLOR_W-1:0] color_i,
  input  logic               q_full_i,
  output logic               q_wr_o,
  output line_cmd_t          q_cmd_o
);

  count_t cnt_x;
  count_t cnt_y;
  logic   x_major;

  // Per-axis pixel counts
  assign cnt_x   = extent_count(extent_x_i);
  assign cnt_y   = extent_count(extent_y_i);
  // Ties go to x
  assign x_major = (cnt_x >= cnt_y);

  // Build the queued word
  always_comb begin
    q_cmd_o.x       = pos_to_coord(start_x_i);
    q_cmd_o.y       = pos_to_coord(start_y_i);
    q_cmd_o.color   = color_i;
    q_cmd_o.major   = x_major ? cnt_x : cnt_y;
    q_cmd_o.minor   = x_major ? cnt_y : cnt_x;
    q_cmd_o.x_major = x_major;
    q_cmd_o.neg_x   = extent_x_i[EXT_W-1];
    q_cmd_o.neg_y   = extent_y_i[EXT_W-1];
  end

  assign q_wr_o = push & ~q_full_i;

endmodule

/* rtl/lpr_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// lpr_cmd_fifo
// Short command queue that decouples the front end from the stepper.
// ----------------------------------------------------------------------------
module lpr_cmd_fifo import lpr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  line_cmd_t wr_data_i,
  output logic      full_o,
  input  logic      rd_i,
  output line_cmd_t rd_data_o,
  output logic      empty_o
);

  line_cmd_t         mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              do_wr, do_rd;

  assign full_o    = (fill_q == FILL_W'(FIFO_DEPTH));
  assign empty_o   = (fill_q == '0);
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & ~empty_o;
  assign rd_data_o = mem[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (do_rd && !do_wr) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* rtl/lpr_back.sv */
// ----------------------------------------------------------------------------
// lpr_back
// Bresenham stepper: walks one command along its major axis, one pixel per
// cycle when not stalled, into an output register that the receiver drains.
// ----------------------------------------------------------------------------
module lpr_back import lpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  line_cmd_t          q_cmd_i,
  output logic               q_rd_o,
  output logic               empty,
  input  logic               pop,
  output logic [POS_W-1:0]   pixel_x_o,
  output logic [POS_W-1:0]   pixel_y_o,
  output logic [COLOR_W-1:0] pixel_color_o,
  output logic               last_pixel_o
);

  // Control
  logic      busy_q, busy_d;
  logic      out_vld_q, out_vld_d;
  // Active command and walk state
  line_cmd_t cmd_q;
  count_t    idx_q;
  count_t    err_q;
  coord_t    px_q, py_q;

  logic      load, step, is_last, minor_step;
  logic [CNT_W:0] err_sum;
  count_t    err_d;
  coord_t    step_x, step_y, px_d, py_d;

  assign load = ~busy_q & ~q_empty_i;
  assign step = busy_q & (~out_vld_q | pop);
  assign q_rd_o = load;

  assign is_last = (idx_q == cmd_q.major - count_t'(1));

  // Error accumulator update
  assign err_sum    = {1'b0, err_q} + {1'b0, cmd_q.minor};
  assign minor_step = (err_sum >= {1'b0, cmd_q.major});
  assign err_d      = minor_step ? CNT_W'(err_sum - {1'b0, cmd_q.major}) : CNT_W'(err_sum);

  // Next coordinates: major axis always moves, minor on error overflow
  assign step_x = cmd_q.neg_x ? '1 : coord_t'(1);
  assign step_y = cmd_q.neg_y ? '1 : coord_t'(1);
  assign px_d   = (cmd_q.x_major || minor_step) ? px_q + step_x : px_q;
  assign py_d   = (!cmd_q.x_major || minor_step) ? py_q + step_y : py_q;

  // Control next state
  always_comb begin
    busy_d    = busy_q;
    out_vld_d = out_vld_q;
    if (pop && out_vld_q) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
    end else if (step) begin
      out_vld_d = 1'b1;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Walk state and output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= q_cmd_i;
      px_q  <= q_cmd_i.x;
      py_q  <= q_cmd_i.y;
      idx_q <= '0;
      err_q <= '0;
    end else if (step) begin
      pixel_x_o     <= coord_to_pos(px_q);
      pixel_y_o     <= coord_to_pos(py_q);
      pixel_color_o <= cmd_q.color;
      last_pixel_o  <= is_last;
      px_q          <= px_d;
      py_q          <= py_d;
      idx_q         <= idx_q + count_t'(1);
      err_q         <= err_d;
    end
  end

  assign empty = ~out_vld_q;

endmodule

/* rtl/line_pixel_rasterizer_core.sv */
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_core
// Bresenham line rasterizer: one line command in, one pixel word per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Command side is a queue write port: drive the start point, the signed
//   extents and the color with push; the word is taken at a clock edge where
//   push is high and full is low. Extents beyond +/-MAX_EXTENT saturate.
//   Pixel side is a queue read port: while empty is low the oldest pixel
//   (x, y, color, last flag) is on the ports; pop takes it.
//   A command goes through a classifier, a two-entry command queue and the
//   stepper: the queue takes it, the stepper loads it, and the first step
//   registers its first pixel. The stepper emits one pixel per cycle while
//   pop keeps up: a command of N pixels (N = max(|dx|,|dy|)+1, up to 64)
//   is loaded, then walked pixel by pixel. Up to two more commands wait
//   in the queue, so full rises only when the stepper is busy and the
//   queue is full. When pop is held low the stepper stalls with its output
//   word held; the queue keeps taking commands until it fills.
//   Reset empties the queue and the output register and idles the stepper.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_core import lpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Command channel
  input  logic               push,
  output logic               full,
  input  logic [POS_W-1:0]   start_x_i,
  input  logic [POS_W-1:0]   start_y_i,
  input  logic [EXT_W-1:0]   extent_x_i,
  input  logic [EXT_W-1:0]   extent_y_i,
  input  logic [COLOR_W-1:0] color_i,
  // Pixel channel
  output logic               empty,
  input  logic               pop,
  output logic [POS_W-1:0]   pixel_x_o,
  output logic [POS_W-1:0]   pixel_y_o,
  output logic [COLOR_W-1:0] pixel_color_o,
  output logic               last_pixel_o
);

  logic      q_wr, q_rd, q_empty;
  line_cmd_t q_wr_cmd, q_rd_cmd;

  // Classifier
  lpr_front u_front (
    .push       (push),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .extent_x_i (extent_x_i),
    .extent_y_i (extent_y_i),
    .color_i    (color_i),
    .q_full_i   (full),
    .q_wr_o     (q_wr),
    .q_cmd_o    (q_wr_cmd)
  );

  // Command queue
  lpr_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_cmd),
    .full_o    (full),
    .rd_i      (q_rd),
    .rd_data_o (q_rd_cmd),
    .empty_o   (q_empty)
  );

  // Stepper
  lpr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_cmd_i       (q_rd_cmd),
    .q_rd_o        (q_rd),
    .empty         (empty),
    .pop           (pop),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule
